// ===== rtl/mqd_pkg.sv =====
// Shared types and constants of the MQTT control packet decoder.
`default_nettype none

package mqd_pkg;

    localparam int          OQ_DEPTH         = 4;
    localparam logic [7:0]  MAX_SUBACK_RESET = 8'd16;
    localparam logic [27:0] MIN_BODY         = 28'd2;

    localparam logic [3:0] TYPE_CONNACK  = 4'd2;
    localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
    localparam logic [3:0] TYPE_PUBACK   = 4'd4;
    localparam logic [3:0] TYPE_SUBACK   = 4'd9;
    localparam logic [3:0] TYPE_UNSUBACK = 4'd11;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LEN,
        PH_C_FLAGS,
        PH_C_CODE,
        PH_ID_HI,
        PH_ID_LO,
        PH_T_HI,
        PH_T_LO,
        PH_TOPIC,
        PH_PAYLOAD,
        PH_ENTRIES
    } t_phase;

    typedef enum logic [1:0] {
        KIND_TOPIC,
        KIND_PAYLOAD,
        KIND_SUBACK_CODE,
        KIND_SUMMARY
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT,
        ST_TOPIC_OVERRUN,
        ST_TOO_MANY,
        ST_BAD_LENGTH
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  field_byte;
        logic [3:0]  packet_type;
        logic [1:0]  qos_level;
        logic [15:0] packet_ident;
        logic [15:0] topic_length;
        logic [27:0] payload_length;
        logic [7:0]  ack_flags;
        logic [7:0]  connack_code;
        logic [7:0]  entry_count;
        t_status     status;
        logic        last;
    } t_result;

    // Up to two results per byte: an optional data result, then an optional summary.
    typedef struct packed {
        logic [1:0] count;
        t_result    slot0;
        t_result    slot1;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/mqd_parser.sv =====
// Byte parser: packet state registers and the per-byte decode step.
`default_nettype none

module mqd_parser import mqd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_packet_start,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    output t_push           o_push
);

    t_phase      r_phase,       n_phase;
    logic [7:0]  r_header,      n_header;
    logic [27:0] r_rem_len,     n_rem_len;
    logic [1:0]  r_len_idx,     n_len_idx;
    logic [27:0] r_bytes_left,  n_bytes_left;
    logic [15:0] r_topic_len,   n_topic_len;
    logic [15:0] r_topic_left,  n_topic_left;
    logic [15:0] r_pkt_id,      n_pkt_id;
    logic [7:0]  r_flags,       n_flags;
    logic [7:0]  r_code,        n_code;
    logic [7:0]  r_entries,     n_entries;
    logic [7:0]  r_max_entries;

    logic [27:0] w_len_part;
    logic [27:0] w_rem_len_acc;
    logic [27:0] w_bl_dec;
    logic [15:0] w_topic_dec;
    logic [15:0] w_tl_new;
    logic [27:0] w_bl_minus_tl;
    logic [3:0]  w_type;
    logic        w_qos_nz;
    logic        w_has_body;
    logic        w_emit_data;
    t_kind       w_data_kind;
    logic        w_emit_sum;
    t_status     w_sum_status;
    logic [28:0] w_used;
    logic [27:0] w_pay_len;
    t_result     w_data_res;
    t_result     w_sum_res;
    t_push       w_push;

    assign w_type     = r_header[7:4];
    assign w_qos_nz   = (r_header[2:1] != 2'd0);
    assign w_has_body = (w_type == TYPE_CONNACK) || (w_type == TYPE_PUBLISH) ||
                        (w_type == TYPE_PUBACK)  || (w_type == TYPE_SUBACK)  ||
                        (w_type == TYPE_UNSUBACK);

    always_comb begin
        unique case (r_len_idx)
            2'd0: w_len_part = {21'd0, i_rx_byte[6:0]};
            2'd1: w_len_part = {14'd0, i_rx_byte[6:0], 7'd0};
            2'd2: w_len_part = {7'd0, i_rx_byte[6:0], 14'd0};
            2'd3: w_len_part = {i_rx_byte[6:0], 21'd0};
        endcase
    end

    assign w_rem_len_acc = r_rem_len | w_len_part;
    assign w_bl_dec      = (r_bytes_left != 28'd0) ? r_bytes_left - 28'd1 : r_bytes_left;
    assign w_topic_dec   = (r_topic_left != 16'd0) ? r_topic_left - 16'd1 : r_topic_left;
    assign w_tl_new      = {r_topic_len[15:8], i_rx_byte};
    assign w_bl_minus_tl = w_bl_dec - {12'd0, w_tl_new};

    // Next state and result events.
    always_comb begin
        n_phase      = r_phase;
        n_header     = r_header;
        n_rem_len    = r_rem_len;
        n_len_idx    = r_len_idx;
        n_bytes_left = r_bytes_left;
        n_topic_len  = r_topic_len;
        n_topic_left = r_topic_left;
        n_pkt_id     = r_pkt_id;
        n_flags      = r_flags;
        n_code       = r_code;
        n_entries    = r_entries;
        w_emit_data  = 1'b0;
        w_data_kind  = KIND_TOPIC;
        w_emit_sum   = 1'b0;
        w_sum_status = ST_OK;

        if (i_accept) begin
            if (i_packet_start) begin
                n_header     = i_rx_byte;
                n_rem_len    = '0;
                n_len_idx    = '0;
                n_bytes_left = '0;
                n_topic_len  = '0;
                n_topic_left = '0;
                n_pkt_id     = '0;
                n_flags      = '0;
                n_code       = '0;
                n_entries    = '0;
                n_phase      = PH_LEN;
            end else begin
                if (r_phase != PH_IDLE && r_phase != PH_LEN) begin
                    n_bytes_left = w_bl_dec;
                end
                unique case (r_phase)
                    PH_IDLE: begin
                    end
                    PH_LEN: begin
                        n_rem_len = w_rem_len_acc;
                        if (i_rx_byte[7]) begin
                            if (r_len_idx == 2'd3) begin
                                w_emit_sum   = 1'b1;
                                w_sum_status = ST_BAD_LENGTH;
                            end else begin
                                n_len_idx = r_len_idx + 2'd1;
                            end
                        end else begin
                            n_bytes_left = w_rem_len_acc;
                            if (!w_has_body) begin
                                w_emit_sum = 1'b1;
                            end else if (w_rem_len_acc < MIN_BODY) begin
                                w_emit_sum   = 1'b1;
                                w_sum_status = ST_SHORT;
                            end else if (w_type == TYPE_CONNACK) begin
                                n_phase = PH_C_FLAGS;
                            end else if (w_type == TYPE_PUBLISH) begin
                                n_phase = PH_T_HI;
                            end else begin
                                n_phase = PH_ID_HI;
                            end
                        end
                    end
                    PH_C_FLAGS: begin
                        n_flags = i_rx_byte;
                        n_phase = PH_C_CODE;
                    end
                    PH_C_CODE: begin
                        n_code     = i_rx_byte;
                        w_emit_sum = 1'b1;
                    end
                    PH_ID_HI: begin
                        n_pkt_id = {i_rx_byte, 8'd0};
                        n_phase  = PH_ID_LO;
                    end
                    PH_ID_LO: begin
                        n_pkt_id = {r_pkt_id[15:8], i_rx_byte};
                        if (w_type == TYPE_PUBLISH) begin
                            if (w_bl_dec == 28'd0) w_emit_sum = 1'b1;
                            else n_phase = PH_PAYLOAD;
                        end else if (w_type == TYPE_SUBACK && w_bl_dec != 28'd0) begin
                            n_phase = PH_ENTRIES;
                        end else begin
                            w_emit_sum = 1'b1;
                        end
                    end
                    PH_T_HI: begin
                        n_topic_len = {i_rx_byte, 8'd0};
                        n_phase     = PH_T_LO;
                    end
                    PH_T_LO: begin
                        n_topic_len = w_tl_new;
                        if ({12'd0, w_tl_new} > w_bl_dec) begin
                            w_emit_sum   = 1'b1;
                            w_sum_status = ST_TOPIC_OVERRUN;
                        end else if (w_qos_nz && w_bl_minus_tl < 28'd2) begin
                            w_emit_sum   = 1'b1;
                            w_sum_status = ST_SHORT;
                        end else begin
                            n_topic_left = w_tl_new;
                            if (w_tl_new != 16'd0) begin
                                n_phase = PH_TOPIC;
                            end else if (w_qos_nz) begin
                                n_phase = PH_ID_HI;
                            end else if (w_bl_dec == 28'd0) begin
                                w_emit_sum = 1'b1;
                            end else begin
                                n_phase = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_TOPIC: begin
                        w_emit_data  = 1'b1;
                        w_data_kind  = KIND_TOPIC;
                        n_topic_left = w_topic_dec;
                        if (w_topic_dec == 16'd0) begin
                            if (w_qos_nz) begin
                                n_phase = PH_ID_HI;
                            end else if (w_bl_dec == 28'd0) begin
                                w_emit_sum = 1'b1;
                            end else begin
                                n_phase = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        w_emit_data = 1'b1;
                        w_data_kind = KIND_PAYLOAD;
                        if (w_bl_dec == 28'd0) w_emit_sum = 1'b1;
                    end
                    PH_ENTRIES: begin
                        if (r_entries >= r_max_entries) begin
                            w_emit_sum   = 1'b1;
                            w_sum_status = ST_TOO_MANY;
                        end else begin
                            w_emit_data = 1'b1;
                            w_data_kind = KIND_SUBACK_CODE;
                            n_entries   = r_entries + 8'd1;
                            if (w_bl_dec == 28'd0) w_emit_sum = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
                if (w_emit_sum) n_phase = PH_IDLE;
            end
        end
    end

    // Result words built from the updated packet fields.
    assign w_used = 29'd2 + {13'd0, n_topic_len} + (w_qos_nz ? 29'd2 : 29'd0);

    always_comb begin
        w_pay_len = '0;
        if (w_type == TYPE_PUBLISH && w_sum_status == ST_OK && {1'b0, n_rem_len} >= w_used) begin
            w_pay_len = n_rem_len - w_used[27:0];
        end

        w_data_res             = '0;
        w_data_res.kind        = w_data_kind;
        w_data_res.field_byte  = i_rx_byte;
        w_data_res.packet_type = w_type;
        w_data_res.qos_level   = r_header[2:1];
        w_data_res.status      = ST_OK;
        w_data_res.last        = !w_emit_sum;

        w_sum_res                = '0;
        w_sum_res.kind           = KIND_SUMMARY;
        w_sum_res.packet_type    = w_type;
        w_sum_res.qos_level      = r_header[2:1];
        w_sum_res.packet_ident   = n_pkt_id;
        w_sum_res.topic_length   = n_topic_len;
        w_sum_res.payload_length = w_pay_len;
        w_sum_res.ack_flags      = n_flags;
        w_sum_res.connack_code   = n_code;
        w_sum_res.entry_count    = n_entries;
        w_sum_res.status         = w_sum_status;
        w_sum_res.last           = 1'b1;

        w_push.count = {1'b0, w_emit_data} + {1'b0, w_emit_sum};
        w_push.slot0 = w_emit_data ? w_data_res : w_sum_res;
        w_push.slot1 = w_sum_res;
    end

    assign o_push = w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_header     <= '0;
            r_rem_len    <= '0;
            r_len_idx    <= '0;
            r_bytes_left <= '0;
            r_topic_len  <= '0;
            r_topic_left <= '0;
            r_pkt_id     <= '0;
            r_flags      <= '0;
            r_code       <= '0;
            r_entries    <= '0;
        end else begin
            r_phase      <= n_phase;
            r_header     <= n_header;
            r_rem_len    <= n_rem_len;
            r_len_idx    <= n_len_idx;
            r_bytes_left <= n_bytes_left;
            r_topic_len  <= n_topic_len;
            r_topic_left <= n_topic_left;
            r_pkt_id     <= n_pkt_id;
            r_flags      <= n_flags;
            r_code       <= n_code;
            r_entries    <= n_entries;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_SUBACK_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_entries <= i_cfg_wr_data;
        end
    end

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.count == 2'd2 |->
            w_push.slot0.kind != KIND_SUMMARY && w_push.slot1.kind == KIND_SUMMARY)
        else $error("two results without data-then-summary order");

    a_sum_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit_sum |=> r_phase == PH_IDLE)
        else $error("parser not idle after a summary");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE && i_accept && !i_packet_start) |-> w_push.count == 2'd0)
        else $error("result produced from an idle byte");

    a_topic_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_topic_left <= r_topic_len)
        else $error("topic byte count exceeds topic length");

endmodule

`default_nettype wire

// ===== rtl/mqd_out_queue.sv =====
// Result queue: takes up to two results per cycle, hands out one per transfer.
`default_nettype none

module mqd_out_queue import mqd_pkg::*; #(
    parameter int P_DEPTH = OQ_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_push   i_push,
    output logic         o_room_low,
    output t_result      o_head,
    output logic         o_valid,
    input  wire logic    i_stall
);

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    t_result          r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] w_wr_ptr1;
    logic [PTR_W-1:0] w_wr_ptr2;
    logic             w_pop;

    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] p);
        f_inc = (p == PTR_W'(P_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign w_wr_ptr1  = f_inc(r_wr_ptr);
    assign w_wr_ptr2  = f_inc(w_wr_ptr1);
    assign w_pop      = (r_count != '0) && !i_stall;
    // Hold the input while fewer than two slots are free.
    assign o_room_low = r_count > CNT_W'(P_DEPTH - 2);
    assign o_valid    = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) r_mem[r_wr_ptr] <= i_push.slot0;
        if (i_push.count == 2'd2) r_mem[w_wr_ptr1] <= i_push.slot1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.count == 2'd1) r_wr_ptr <= w_wr_ptr1;
            else if (i_push.count == 2'd2) r_wr_ptr <= w_wr_ptr2;
            if (w_pop) r_rd_ptr <= f_inc(r_rd_ptr);
            r_count <= r_count + CNT_W'(i_push.count) - CNT_W'(w_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) + int'(i_push.count) <= P_DEPTH)
        else $error("result queue overflow");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_wr_ptr == r_rd_ptr)
        else $error("empty queue with unequal pointers");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_ptr <= PTR_W'(P_DEPTH - 1) && r_rd_ptr <= PTR_W'(P_DEPTH - 1))
        else $error("queue pointer out of range");

endmodule

`default_nettype wire

// ===== rtl/mqtt_packet_decoder_unit.sv =====
// MQTT control packet decoder: one received byte per transfer in, parsed results out.
// A byte's results are registered in the result queue; a second result follows the first.
// One byte per cycle unless stalled; a byte causes at most two results (data, then summary).
// The input stalls while the result queue (P_OQ_DEPTH entries) has fewer than two free slots.
// Reset (synchronous, active low): parser idle, packet fields zero, SUBACK limit 16,
// result queue empty.
`default_nettype none

module mqtt_packet_decoder_unit import mqd_pkg::*; #(
    parameter int P_OQ_DEPTH = OQ_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_packet_start,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_field_byte,
    output logic [3:0]       o_packet_type,
    output logic [1:0]       o_qos_level,
    output logic [15:0]      o_packet_ident,
    output logic [15:0]      o_topic_length,
    output logic [27:0]      o_payload_length,
    output logic [7:0]       o_ack_flags,
    output logic [7:0]       o_connack_code,
    output logic [7:0]       o_entry_count,
    output logic [2:0]       o_status,
    output logic             o_last
);

    t_push   w_push;
    t_result w_head;
    logic    w_room_low;
    logic    w_accept;

    assign o_in_stall = w_room_low;
    assign w_accept   = i_in_valid && !w_room_low;

    mqd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_rx_byte      (i_rx_byte),
        .i_packet_start (i_packet_start),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_push         (w_push)
    );

    mqd_out_queue #(
        .P_DEPTH (P_OQ_DEPTH)
    ) u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_room_low (w_room_low),
        .o_head     (w_head),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall)
    );

    assign o_kind           = w_head.kind;
    assign o_field_byte     = w_head.field_byte;
    assign o_packet_type    = w_head.packet_type;
    assign o_qos_level      = w_head.qos_level;
    assign o_packet_ident   = w_head.packet_ident;
    assign o_topic_length   = w_head.topic_length;
    assign o_payload_length = w_head.payload_length;
    assign o_ack_flags      = w_head.ack_flags;
    assign o_connack_code   = w_head.connack_code;
    assign o_entry_count    = w_head.entry_count;
    assign o_status         = w_head.status;
    assign o_last           = w_head.last;

endmodule

`default_nettype wire
